[rtl/sklc_pkg.sv]
// Shared constants and types for the small-kernel correlator.
`default_nettype none

package sklc_pkg;

  // Parameter defaults
  localparam int MAX_TAPS_DEF     = 11;
  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int TAP_WIDTH_DEF    = 16;

  // Fixed field widths
  localparam int IN_SAMPLE_W  = 16;
  localparam int IN_TUSER_W   = 1;
  localparam int OUT_W        = 35;
  localparam int OUT_TDATA_W  = 40;
  localparam int TAP_COUNT_W  = 4;
  localparam int CFG_DATA_W   = 64;
  localparam int CFG_IDX_W    = 2;
  localparam int HIGH_GROUP_W = 48;

  // Tap bank layout: 16-bit slots, room for twelve taps
  localparam int SLOT_W      = 16;
  localparam int BANK_SLOTS  = 12;
  localparam int TAP_BANK_W  = SLOT_W * BANK_SLOTS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAP_COUNT = 2'd0,
    REG_TAPS_LOW  = 2'd1,
    REG_TAPS_MID  = 2'd2,
    REG_TAPS_HIGH = 2'd3
  } cfg_reg_t;

endpackage

`default_nettype wire

[rtl/sklc_coef.sv]
// Configuration registers and age-ordered coefficient bank.
`default_nettype none

module sklc_coef #(
  parameter int MAX_TAPS  = sklc_pkg::MAX_TAPS_DEF,
  parameter int TAP_WIDTH = sklc_pkg::TAP_WIDTH_DEF,
  localparam int CNT_W    = $clog2(MAX_TAPS + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_valid_i,
  output      logic                                cfg_ready_o,
  input  wire logic [sklc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  wire logic [sklc_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output      logic [CNT_W-1:0]                    tap_num_o,
  output      logic signed [TAP_WIDTH-1:0]         coef_o [MAX_TAPS]
);
  import sklc_pkg::*;

  logic [TAP_COUNT_W-1:0]  tap_count_r;
  logic [CFG_DATA_W-1:0]   taps_low_r;
  logic [CFG_DATA_W-1:0]   taps_mid_r;
  logic [HIGH_GROUP_W-1:0] taps_high_r;
  logic [TAP_BANK_W-1:0]   tap_bank;
  logic [CNT_W-1:0]        tap_num;
  logic signed [TAP_WIDTH-1:0] coef_nxt [MAX_TAPS];
  logic signed [TAP_WIDTH-1:0] coef_r   [MAX_TAPS];
  logic                    cfg_we;

  assign cfg_ready_o = rst_n;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tap_count_r <= TAP_COUNT_W'(1);
      taps_low_r  <= '0;
      taps_mid_r  <= '0;
      taps_high_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index_i))
        REG_TAP_COUNT: tap_count_r <= cfg_data_i[TAP_COUNT_W-1:0];
        REG_TAPS_LOW:  taps_low_r  <= cfg_data_i;
        REG_TAPS_MID:  taps_mid_r  <= cfg_data_i;
        REG_TAPS_HIGH: taps_high_r <= cfg_data_i[HIGH_GROUP_W-1:0];
        default: ;
      endcase
    end
  end

  // Top slot stays zero: a twelfth tap reads as zero.
  assign tap_bank = {{(TAP_BANK_W - 2*CFG_DATA_W - HIGH_GROUP_W){1'b0}},
                     taps_high_r, taps_mid_r, taps_low_r};

  // Zero taps means one, above MAX_TAPS saturates.
  always_comb begin
    if (tap_count_r == '0) begin
      tap_num = CNT_W'(1);
    end else if (tap_count_r > TAP_COUNT_W'(MAX_TAPS)) begin
      tap_num = CNT_W'(MAX_TAPS);
    end else begin
      tap_num = CNT_W'(tap_count_r);
    end
  end

  // Lane a carries the sample of age a, so it takes tap (n-1-a).
  always_comb begin
    logic [CNT_W-1:0] idx;
    for (int a = 0; a < MAX_TAPS; a++) begin
      idx = tap_num - CNT_W'(1) - CNT_W'(a);
      if (CNT_W'(a) < tap_num) begin
        coef_nxt[a] = tap_bank[SLOT_W*idx +: TAP_WIDTH];
      end else begin
        coef_nxt[a] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    coef_r <= coef_nxt;
  end

  assign tap_num_o = tap_num;
  assign coef_o    = coef_r;

endmodule

`default_nettype wire

[rtl/sklc_window.sv]
// Input stage: fill count, sample delay line and window register.
`default_nettype none

module sklc_window #(
  parameter int MAX_TAPS     = sklc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = sklc_pkg::SAMPLE_WIDTH_DEF,
  localparam int CNT_W       = $clog2(MAX_TAPS + 1)
) (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 in_valid_i,
  output      logic                                 in_ready_o,
  input  wire logic [sklc_pkg::IN_SAMPLE_W-1:0]     sample_i,
  input  wire logic                                 start_i,
  input  wire logic [CNT_W-1:0]                     tap_num_i,
  output      logic                                 win_valid_o,
  input  wire logic                                 win_ready_i,
  output      logic signed [SAMPLE_WIDTH-1:0]       win_o [MAX_TAPS]
);
  import sklc_pkg::*;

  logic signed [SAMPLE_WIDTH-1:0] cur;
  logic signed [SAMPLE_WIDTH-1:0] win_r [MAX_TAPS];
  logic [CNT_W-1:0]               fill_r;
  logic [CNT_W-1:0]               fill_base;
  logic [CNT_W-1:0]               fill_nxt;
  logic                           win_valid_r;
  logic                           emit;
  logic                           accept;

  generate
    if (SAMPLE_WIDTH <= IN_SAMPLE_W) begin : g_narrow
      assign cur = sample_i[SAMPLE_WIDTH-1:0];
    end else begin : g_wide
      assign cur = {{(SAMPLE_WIDTH - IN_SAMPLE_W){1'b0}}, sample_i};
    end
  endgenerate

  assign in_ready_o = rst_n && (!win_valid_r || win_ready_i);
  assign accept     = in_valid_i && in_ready_o;

  // Start flag clears the count before this sample is counted.
  assign fill_base = start_i ? '0 : fill_r;
  assign fill_nxt  = (fill_base < CNT_W'(MAX_TAPS)) ? fill_base + CNT_W'(1) : fill_base;
  assign emit      = (fill_nxt >= tap_num_i);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      win_valid_r <= 1'b0;
    end else if (accept) begin
      fill_r      <= fill_nxt;
      win_valid_r <= emit;
    end else if (win_ready_i) begin
      win_valid_r <= 1'b0;
    end
  end

  // Delay line and window clear on reset; unused lanes then multiply zero.
  generate
    if (MAX_TAPS > 1) begin : g_hist
      logic signed [SAMPLE_WIDTH-1:0] hist_r [MAX_TAPS-1];

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          for (int i = 0; i < MAX_TAPS - 1; i++) begin
            hist_r[i] <= '0;
          end
          for (int a = 0; a < MAX_TAPS; a++) begin
            win_r[a] <= '0;
          end
        end else if (accept) begin
          hist_r[0] <= cur;
          for (int i = 1; i < MAX_TAPS - 1; i++) begin
            hist_r[i] <= hist_r[i-1];
          end
          win_r[0] <= cur;
          for (int a = 1; a < MAX_TAPS; a++) begin
            win_r[a] <= hist_r[a-1];
          end
        end
      end
    end else begin : g_nohist
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          win_r[0] <= '0;
        end else if (accept) begin
          win_r[0] <= cur;
        end
      end
    end
  endgenerate

  assign win_valid_o = win_valid_r;
  assign win_o       = win_r;

endmodule

`default_nettype wire

[rtl/sklc_mac.sv]
// Multiply, partial-sum and final-sum stages with the output register.
`default_nettype none

module sklc_mac #(
  parameter int MAX_TAPS     = sklc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = sklc_pkg::SAMPLE_WIDTH_DEF,
  parameter int TAP_WIDTH    = sklc_pkg::TAP_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              win_valid_i,
  output      logic                              win_ready_o,
  input  wire logic signed [SAMPLE_WIDTH-1:0]    win_i  [MAX_TAPS],
  input  wire logic signed [TAP_WIDTH-1:0]       coef_i [MAX_TAPS],
  output      logic                              out_valid_o,
  input  wire logic                              out_ready_i,
  output      logic [sklc_pkg::OUT_W-1:0]        out_data_o
);
  import sklc_pkg::*;

  localparam int PROD_W   = SAMPLE_WIDTH + TAP_WIDTH;
  localparam int ACC_W    = (PROD_W + 4 > OUT_W) ? PROD_W + 4 : OUT_W;
  localparam int GRP_SIZE = 4;
  localparam int NGRP     = (MAX_TAPS + GRP_SIZE - 1) / GRP_SIZE;

  logic signed [PROD_W-1:0] prod_r   [MAX_TAPS];
  logic signed [ACC_W-1:0]  part_nxt [NGRP];
  logic signed [ACC_W-1:0]  part_r   [NGRP];
  logic signed [ACC_W-1:0]  sum_nxt;
  logic [OUT_W-1:0]         out_data_r;
  logic                     prod_valid_r;
  logic                     part_valid_r;
  logic                     out_valid_r;
  logic                     out_adv;
  logic                     part_adv;
  logic                     prod_adv;

  assign out_adv     = !out_valid_r  || out_ready_i;
  assign part_adv    = !part_valid_r || out_adv;
  assign prod_adv    = !prod_valid_r || part_adv;
  assign win_ready_o = prod_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
      part_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (prod_adv) prod_valid_r <= win_valid_i;
      if (part_adv) part_valid_r <= prod_valid_r;
      if (out_adv)  out_valid_r  <= part_valid_r;
    end
  end

  // One multiplier per lane.
  always_ff @(posedge clk) begin
    if (prod_adv && win_valid_i) begin
      for (int a = 0; a < MAX_TAPS; a++) begin
        prod_r[a] <= PROD_W'(win_i[a] * coef_i[a]);
      end
    end
  end

  // Groups of four products.
  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      part_nxt[g] = '0;
      for (int k = 0; k < GRP_SIZE; k++) begin
        if (g*GRP_SIZE + k < MAX_TAPS) begin
          part_nxt[g] = part_nxt[g] + ACC_W'(prod_r[g*GRP_SIZE + k]);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (part_adv && prod_valid_r) begin
      part_r <= part_nxt;
    end
  end

  always_comb begin
    sum_nxt = '0;
    for (int g = 0; g < NGRP; g++) begin
      sum_nxt = sum_nxt + part_r[g];
    end
  end

  // Result wraps to the output width.
  always_ff @(posedge clk) begin
    if (out_adv && part_valid_r) begin
      out_data_r <= sum_nxt[OUT_W-1:0];
    end
  end

  assign out_valid_o = out_valid_r;
  assign out_data_o  = out_data_r;

endmodule

`default_nettype wire

[rtl/small_kernel_correlator_unit.sv]
// Top level of the streaming small-kernel correlator (direct-form FIR, kernel not reversed).
// Throughput: one sample per cycle while out_tready is high; four register stages
// (window, multiply, partial sum, output) each hand off on a ready chain, so stalls
// back up without bubbles.
// Reset (rst_n low, synchronous): pipeline emptied, fill count zero, tap_count 1,
// all tap groups zero. in_tready and cfg_ready stay low while reset is held.
`default_nettype none

module small_kernel_correlator_unit #(
  parameter int MAX_TAPS     = sklc_pkg::MAX_TAPS_DEF,
  parameter int SAMPLE_WIDTH = sklc_pkg::SAMPLE_WIDTH_DEF,
  parameter int TAP_WIDTH    = sklc_pkg::TAP_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  // Input stream
  input  wire logic                                in_tvalid,
  output      logic                                in_tready,
  input  wire logic [sklc_pkg::IN_SAMPLE_W-1:0]    in_tdata,  // [15:0] sample
  input  wire logic [sklc_pkg::IN_TUSER_W-1:0]     in_tuser,  // [0] start_of_row
  // Result stream
  output      logic                                out_tvalid,
  input  wire logic                                out_tready,
  output      logic [sklc_pkg::OUT_TDATA_W-1:0]    out_tdata, // [34:0] filtered, [39:35] zero
  // Configuration writes
  input  wire logic                                cfg_valid,
  output      logic                                cfg_ready,
  input  wire logic [sklc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [sklc_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import sklc_pkg::*;

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  logic [CNT_W-1:0]               tap_num;
  logic signed [TAP_WIDTH-1:0]    coef [MAX_TAPS];
  logic signed [SAMPLE_WIDTH-1:0] win  [MAX_TAPS];
  logic                           win_valid;
  logic                           win_ready;
  logic [OUT_W-1:0]               out_data;

  // Config registers. The coefficient bank is re-ordered by sample age and
  // registered. The user must change config only while idle; the block does not
  // enforce it. Then the register lag never reaches the multiply stage.
  sklc_coef #(
    .MAX_TAPS  (MAX_TAPS),
    .TAP_WIDTH (TAP_WIDTH)
  ) u_coef (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .tap_num_o   (tap_num),
    .coef_o      (coef)
  );

  // Delay line and fill count. Samples that do not complete a window update
  // the history but never enter the pipeline.
  sklc_window #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_window (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid_i  (in_tvalid),
    .in_ready_o  (in_tready),
    .sample_i    (in_tdata),
    .start_i     (in_tuser[0]),
    .tap_num_i   (tap_num),
    .win_valid_o (win_valid),
    .win_ready_i (win_ready),
    .win_o       (win)
  );

  // Lane products, grouped partial sums, final sum into the output register.
  sklc_mac #(
    .MAX_TAPS     (MAX_TAPS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .TAP_WIDTH    (TAP_WIDTH)
  ) u_mac (
    .clk         (clk),
    .rst_n       (rst_n),
    .win_valid_i (win_valid),
    .win_ready_o (win_ready),
    .win_i       (win),
    .coef_i      (coef),
    .out_valid_o (out_tvalid),
    .out_ready_i (out_tready),
    .out_data_o  (out_data)
  );

  assign out_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, out_data};

endmodule

`default_nettype wire

[rtl/sklc_checker.sv]
// Port-level checker for the correlator, bound to the top level.
`default_nettype none

module sklc_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_tvalid,
  input wire logic                              in_tready,
  input wire logic                              out_tvalid,
  input wire logic                              out_tready,
  input wire logic [sklc_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import sklc_pkg::*;

  logic idle_flow;

  // No new transaction in and the result side draining.
  assign idle_flow = !(in_tvalid && in_tready) && out_tready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before its transaction completed");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> $stable(out_tdata))
    else $error("out_tdata changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result pending right after reset");

  // With no input and the result side free-flowing, the four-stage pipeline empties.
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    idle_flow && $past(idle_flow, 1) && $past(idle_flow, 2) && $past(idle_flow, 3)
    |=> !out_tvalid)
    else $error("pipeline produced a result with no input transaction");

  // Padding bits above the result stay zero.
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[OUT_TDATA_W-1:OUT_W] == '0))
    else $error("out_tdata padding not zero");

endmodule

bind small_kernel_correlator_unit sklc_checker u_sklc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

[tb/tb_top.sv]
// Self-checking testbench for the streaming small-kernel correlator.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sklc_pkg::*;

  localparam int TAPS_MAX   = MAX_TAPS_DEF;
  localparam int HIST_DEPTH = TAPS_MAX - 1;
  localparam int N_PHASES   = 8;
  localparam int PHASE_LEN  = 53;
  localparam int SETTLE_CYC = 8;   // pipeline is 4 stages deep; covers items with no result

  // Scoreboard: mirrors the filter state, keeps the expected results in order
  // and compares every output transaction against the oldest one.
  class corr_scoreboard;
    logic [TAP_COUNT_W-1:0]  tap_count;
    logic [63:0]             taps_low;
    logic [63:0]             taps_mid;
    logic [HIGH_GROUP_W-1:0] taps_high;
    logic signed [15:0]      history[HIST_DEPTH];
    int unsigned             fill;
    logic [OUT_W-1:0]        expected_sums[$];
    int                      errors;

    function new();
      tap_count = TAP_COUNT_W'(1);
      taps_low  = '0;
      taps_mid  = '0;
      taps_high = '0;
      foreach (history[i]) history[i] = '0;
      fill   = 0;
      errors = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
      case (idx)
        REG_TAP_COUNT: tap_count = d[TAP_COUNT_W-1:0];
        REG_TAPS_LOW:  taps_low  = d;
        REG_TAPS_MID:  taps_mid  = d;
        REG_TAPS_HIGH: taps_high = d[HIGH_GROUP_W-1:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] tap_at(int t);
      logic [HIGH_GROUP_W+127:0] bank;
      bank = {taps_high, taps_mid, taps_low};
      return bank[16*t +: 16];
    endfunction

    // Accepted input sample: advance fill count, form the window sum, shift history.
    function void note_sample(logic signed [15:0] s, bit start);
      int n;
      int age;
      longint acc;
      logic signed [15:0] x;
      n = tap_count;
      if (n < 1) n = 1;
      if (n > TAPS_MAX) n = TAPS_MAX;
      if (start) fill = 0;
      if (fill < TAPS_MAX) fill++;
      acc = 0;
      for (int j = 0; j < n; j++) begin
        age = n - 1 - j;
        x = (age == 0) ? s : history[age-1];
        acc += longint'(x) * longint'(tap_at(j));
      end
      for (int i = HIST_DEPTH - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = s;
      if (fill >= n) expected_sums.push_back(acc[OUT_W-1:0]);
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d);
      logic [OUT_W-1:0] want;
      if (expected_sums.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: unexpected result %0d", $signed(d[OUT_W-1:0]));
        return;
      end
      want = expected_sums.pop_front();
      if (d[OUT_W-1:0] !== want) begin
        errors++;
        if (errors <= 10)
          $display("ERROR: filtered mismatch: expected %0d, got %0d",
                   $signed(want), $signed(d[OUT_W-1:0]));
      end
    endfunction

    function int pending();
      return expected_sums.size();
    endfunction
  endclass

  // DUT inputs start at known values
  logic                      clk        = 1'b0;
  logic                      rst_n      = 1'b0;
  logic                      in_tvalid  = 1'b0;
  logic [IN_SAMPLE_W-1:0]    in_tdata   = '0;   // [15:0] sample
  logic [IN_TUSER_W-1:0]     in_tuser   = '0;   // [0] start_of_row
  logic                      out_tready = 1'b0;
  logic                      cfg_valid  = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index  = '0;
  logic [CFG_DATA_W-1:0]     cfg_data   = '0;
  logic                      in_tready;
  logic                      out_tvalid;
  logic [OUT_TDATA_W-1:0]    out_tdata;  // [34:0] filtered, [39:35] zero
  logic                      cfg_ready;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int row_left       = 0;

  corr_scoreboard sb = new();

  small_kernel_correlator_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Transaction monitors: sampled at the rising edge, before any RTL update lands.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
      if (in_tvalid && in_tready) sb.note_sample(in_tdata, in_tuser[0]);
      if (out_tvalid && out_tready) sb.check_result(out_tdata);
    end
  end

  // Result side backpressure, redrawn every falling edge
  always @(negedge clk) begin
    out_tready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Called at a falling edge; returns at the falling edge after the handshake.
  // tvalid stays high on return so back-to-back transactions have no bubble.
  task automatic send_sample(input logic [15:0] s, input bit start);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid   = 1'b1;
    in_tdata    = s;
    in_tuser[0] = start;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic cfg_write(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] d);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = d;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Hold off the sender until every expected result has come back, then let
  // any sample still in flight without a result clear the pipe.
  task automatic drain();
    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(11))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'h0000;
      3:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [63:0] tap_pattern(int mode);
    logic [63:0] w;
    case (mode)
      0:       w = {16'h8000, 16'h8000, 16'h8000, 16'h8000};
      1:       w = {16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF};
      2:       w = {$urandom_range(15), $urandom_range(15)} - 64'd8;  // small taps
      default: w = {$urandom, $urandom};
    endcase
    return w;
  endfunction

  // Tap counts: zero and above max are covered along with the legal extremes.
  function automatic logic [3:0] phase_tap_count(int p);
    case (p)
      0:       return 4'd0;
      1:       return 4'd15;
      2:       return 4'd1;
      3:       return 4'd11;
      4:       return 4'd12;
      7:       return 4'd11;
      default: return 4'($urandom_range(15));
    endcase
  endfunction

  initial begin
    logic [63:0] tc_word;
    int          mode;
    bit          start;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: reset defaults (one tap of zero) give zero results.
    send_sample(16'h7FFF, 1'b1);
    send_sample(16'h8000, 1'b0);
    drain();

    // Full kernel of most negative taps against most negative samples: largest sum.
    cfg_write(REG_TAP_COUNT, 64'd11);
    cfg_write(REG_TAPS_LOW,  tap_pattern(0));
    cfg_write(REG_TAPS_MID,  tap_pattern(0));
    cfg_write(REG_TAPS_HIGH, tap_pattern(0));
    for (int k = 0; k < 11; k++) send_sample(16'h8000, k == 0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h7FFF, 1'b0);
    // New row mid-stream: old history must not reach a result.
    for (int k = 0; k < 11; k++) send_sample((k % 2) ? 16'h7FFF : 16'h8000, k == 0);
    drain();

    // Random phases; rows run across phase boundaries, so a tap count
    // change also lands in the middle of a row.
    for (int p = 0; p < N_PHASES; p++) begin
      case (p % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 11; recv_stall_pct = 11; end
      endcase

      // Upper bits of a tap count write are junk half the time; only the low nibble counts.
      tc_word = {$urandom, $urandom};
      tc_word = {($urandom_range(1) ? tc_word[63:4] : 60'd0), phase_tap_count(p)};
      cfg_write(REG_TAP_COUNT, tc_word);
      mode = (p == 7) ? 1 : (p == 2) ? 2 : $urandom_range(3);
      cfg_write(REG_TAPS_LOW,  tap_pattern(mode));
      cfg_write(REG_TAPS_MID,  tap_pattern(mode));
      cfg_write(REG_TAPS_HIGH, tap_pattern(mode) | ({$urandom, $urandom} & 64'hFFFF_0000_0000_0000));

      for (int k = 0; k < PHASE_LEN; k++) begin
        if (row_left == 0) begin
          start    = 1'b1;
          row_left = ($urandom_range(4) == 0) ? $urandom_range(1, 10) : $urandom_range(11, 40);
        end else begin
          start = ($urandom_range(39) == 0);  // stray row start
        end
        row_left--;
        send_sample(pick_sample(), start);
        if (p == 2 && k == PHASE_LEN / 2) drain();
      end
      drain();
    end

    in_tvalid = 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Watchdog
  initial begin
    #3ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

`default_nettype wire

[files.f]
rtl/sklc_pkg.sv
rtl/sklc_coef.sv
rtl/sklc_window.sv
rtl/sklc_mac.sv
rtl/small_kernel_correlator_unit.sv
rtl/sklc_checker.sv
tb/tb_top.sv
